>>> hw/rtl/length_prefixed_field_splitter_macros.svh
// Assertion macros shared by the field splitter RTL.
// Depends on nothing; included by lpfs_parser and the top level.
`ifndef LENGTH_PREFIXED_FIELD_SPLITTER_MACROS_SVH
`define LENGTH_PREFIXED_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFS_ASSERT_IMP(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("lpfs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPFS_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("lpfs assertion failed");

`endif

>>> hw/rtl/lpfs_pkg.sv
// Types and constants for the length-prefixed field splitter.
// Depends on nothing; used by lpfs_parser and the top level.
package lpfs_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;
    localparam int LEN_W   = 32;
    localparam int ACC_W   = 24;
    localparam int HDR_W   = 2;

    localparam logic [HDR_W-1:0] HDR_LAST = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              end_of_message;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic [INDEX_W-1:0] field_index;
        logic               field_end;
        logic               message_done;
        logic               well_formed;
    } result_t;

endpackage

>>> hw/rtl/length_prefixed_field_splitter.sv
// Length-prefixed field splitter: splits a byte stream into fields.
// Each field is a 4-byte big-endian length followed by that many bytes.
// The input channel (in_valid/in_ready) takes one word per cycle: a byte,
// a flag telling whether the byte is present, and an end-of-message flag.
// The output channel (out_valid/out_ready) gives at most one word per
// input word: a payload byte with its field index, a field_end mark on the
// last byte of a field or on an empty field, and at the end of a message
// a done flag with the well_formed verdict.
// A word is accepted into the input register, where the parser works on
// it, and its result is then taken into the result register that drives
// out_valid. The splitter takes one word per cycle while the output is
// not stalled; the parser updates the header count and the 32-bit
// remaining-length counter for each word that it takes.
// Reset clears both valid flags and the parser state, so a new message may
// start at once. When the receiver stalls, the result register holds its
// word, the input register fills behind it, and in_ready drops; words that
// give no result still drain past a stalled output.
// Depends on lpfs_pkg, lpfs_parser and the assertion macro header.
`include "length_prefixed_field_splitter_macros.svh"

module length_prefixed_field_splitter #(
    parameter int MAX_FIELDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lpfs_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          has_byte,
    input  logic                          end_of_message,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lpfs_pkg::BYTE_W-1:0]   out_byte,
    output logic                          byte_valid,
    output logic [lpfs_pkg::INDEX_W-1:0]  field_index,
    output logic                          field_end,
    output logic                          message_done,
    output logic                          well_formed
);

    logic              s1_valid_reg;
    lpfs_pkg::item_t   s1_item_reg;
    logic              o_valid_reg;
    lpfs_pkg::result_t o_res_reg;

    lpfs_pkg::result_t res;
    logic              emit;
    logic              out_free;
    logic              s1_advance;

    assign out_free   = !o_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!emit || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    lpfs_parser #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_parser (
        .clk  (clk),
        .rst_n(rst_n),
        .step (s1_advance),
        .item (s1_item_reg),
        .res  (res),
        .emit (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg.data_byte      <= data_byte;
            s1_item_reg.has_byte       <= has_byte;
            s1_item_reg.end_of_message <= end_of_message;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            o_valid_reg <= s1_advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_advance && emit)
        begin
            o_res_reg <= res;
        end
    end

    assign out_valid    = o_valid_reg;
    assign out_byte     = o_res_reg.out_byte;
    assign byte_valid   = o_res_reg.byte_valid;
    assign field_index  = o_res_reg.field_index;
    assign field_end    = o_res_reg.field_end;
    assign message_done = o_res_reg.message_done;
    assign well_formed  = o_res_reg.well_formed;

    // The verdict is only ever reported together with the end of a message.
    `LPFS_ASSERT_IMP(a_ok_needs_done, clk, rst_n, o_valid_reg && !message_done, !well_formed)
    // A field index never exceeds the field limit.
    `LPFS_ASSERT_IMP(a_index_range, clk, rst_n, o_valid_reg, field_index <= 7'(MAX_FIELDS))
    // A word held in the input register is never dropped while it waits.
    `LPFS_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !s1_advance, s1_valid_reg)

endmodule

>>> hw/rtl/lpfs_parser.sv
// Field parser state and next-state logic for one word per step.
// Depends on lpfs_pkg and length_prefixed_field_splitter_macros.svh.
`include "length_prefixed_field_splitter_macros.svh"

module lpfs_parser #(
    parameter int MAX_FIELDS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  lpfs_pkg::item_t  item,
    output lpfs_pkg::result_t res,
    output logic             emit
);

    logic [lpfs_pkg::HDR_W-1:0]   hdr_cnt_reg;
    logic [lpfs_pkg::HDR_W-1:0]   hdr_cnt_next;
    logic [lpfs_pkg::ACC_W-1:0]   acc_reg;
    logic [lpfs_pkg::ACC_W-1:0]   acc_next;
    logic [lpfs_pkg::LEN_W-1:0]   rem_reg;
    logic [lpfs_pkg::LEN_W-1:0]   rem_next;
    logic [lpfs_pkg::INDEX_W-1:0] fields_reg;
    logic [lpfs_pkg::INDEX_W-1:0] fields_next;
    logic                         err_reg;
    logic                         err_next;

    logic                         active;
    logic                         hdr_phase;
    logic                         payload;
    logic                         completes;
    logic                         overflow;
    logic                         emit_data;
    logic                         err_final;
    logic [lpfs_pkg::LEN_W-1:0]   len;
    logic [lpfs_pkg::HDR_W-1:0]   hdr_after;
    logic [lpfs_pkg::ACC_W-1:0]   acc_after;
    logic [lpfs_pkg::LEN_W-1:0]   rem_after;
    logic [lpfs_pkg::INDEX_W-1:0] fields_after;
    logic                         err_after;

    always_comb
    begin
        active    = item.has_byte && !err_reg;
        hdr_phase = (rem_reg == '0);
        payload   = active && !hdr_phase;
        len       = {acc_reg, item.data_byte};

        hdr_after = hdr_cnt_reg;
        acc_after = acc_reg;
        rem_after = rem_reg;
        completes = 1'b0;

        if (active && hdr_phase)
        begin
            if (hdr_cnt_reg != lpfs_pkg::HDR_LAST)
            begin
                acc_after = len[lpfs_pkg::ACC_W-1:0];
                hdr_after = hdr_cnt_reg + 2'd1;
            end
            else
            begin
                acc_after = '0;
                hdr_after = '0;
                rem_after = len;
                completes = (len == '0);
            end
        end
        else if (payload)
        begin
            rem_after = rem_reg - 32'd1;
            completes = (rem_reg == 32'd1);
        end

        overflow     = completes && (fields_reg >= 7'(MAX_FIELDS));
        emit_data    = (payload && !completes) || (completes && !overflow);
        fields_after = (completes && !overflow) ? fields_reg + 7'd1 : fields_reg;
        err_after    = err_reg || overflow;
        err_final    = err_after || (hdr_after != '0) || (rem_after != '0);

        res = '0;
        if (emit_data)
        begin
            res.out_byte    = payload ? item.data_byte : '0;
            res.byte_valid  = payload;
            res.field_index = fields_reg;
            res.field_end   = completes;
        end
        else
        begin
            res.field_index = fields_after;
        end
        res.message_done = item.end_of_message;
        res.well_formed  = item.end_of_message && !err_final;
        emit             = emit_data || item.end_of_message;

        if (item.end_of_message)
        begin
            hdr_cnt_next = '0;
            acc_next     = '0;
            rem_next     = '0;
            fields_next  = '0;
            err_next     = 1'b0;
        end
        else
        begin
            hdr_cnt_next = hdr_after;
            acc_next     = acc_after;
            rem_next     = rem_after;
            fields_next  = fields_after;
            err_next     = err_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
            acc_reg     <= '0;
            rem_reg     <= '0;
            fields_reg  <= '0;
            err_reg     <= 1'b0;
        end
        else if (step)
        begin
            hdr_cnt_reg <= hdr_cnt_next;
            acc_reg     <= acc_next;
            rem_reg     <= rem_next;
            fields_reg  <= fields_next;
            err_reg     <= err_next;
        end
    end

    // A header is never gathered while payload bytes are still due.
    `LPFS_ASSERT_IMP(a_hdr_excl_payload, clk, rst_n, hdr_cnt_reg != '0, rem_reg == '0)
    // Once malformed, only the end of the message produces a result.
    `LPFS_ASSERT_IMP(a_err_quiet, clk, rst_n, step && err_reg, !emit || item.end_of_message)
    // The end of a message returns every counter to its reset value.
    `LPFS_ASSERT_NEXT(a_end_clears, clk, rst_n, step && item.end_of_message,
        hdr_cnt_reg == '0 && rem_reg == '0 && fields_reg == '0 && !err_reg)

endmodule

>>> tb/lpfs_split_checker.sv
`timescale 1ns / 1ps
// Checker for the length-prefixed field splitter: watches both channels, predicts
// each result word from the accepted input words and compares them in order.
// Depends on lpfs_pkg for the result layout and the header byte count.
module lpfs_split_checker #(
    parameter int MAX_FIELDS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [lpfs_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         has_byte,
    input  logic                         end_of_message,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [lpfs_pkg::BYTE_W-1:0]  out_byte,
    input  logic                         byte_valid,
    input  logic [lpfs_pkg::INDEX_W-1:0] field_index,
    input  logic                         field_end,
    input  logic                         message_done,
    input  logic                         well_formed,
    output int                           mismatches,
    output int                           pending
);

    localparam int REPORT_LIMIT = 10;

    lpfs_pkg::result_t            split_due[$];
    logic [lpfs_pkg::HDR_W-1:0]   hdr_count;
    logic [lpfs_pkg::LEN_W-1:0]   len_shift;
    logic [lpfs_pkg::LEN_W-1:0]   payload_left;
    logic [lpfs_pkg::INDEX_W-1:0] fields_done;
    logic                         malformed;
    int                           fail_total;

    function automatic string show_result(input lpfs_pkg::result_t r);
        return $sformatf("byte=%02h byte_valid=%b index=%0d field_end=%b done=%b ok=%b",
                         r.out_byte, r.byte_valid, r.field_index, r.field_end,
                         r.message_done, r.well_formed);
    endfunction

    task automatic note_failure(input string what);
        fail_total++;
        if (fail_total <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    task automatic clear_parse();
        hdr_count    = '0;
        len_shift    = '0;
        payload_left = '0;
        fields_done  = '0;
        malformed    = 1'b0;
    endtask

    task automatic predict_split(input logic [lpfs_pkg::BYTE_W-1:0] b, input logic has,
                                 input logic eom);
        lpfs_pkg::result_t          r;
        logic                       emit;
        logic                       completes;
        logic [lpfs_pkg::LEN_W-1:0] len;
        r         = '0;
        emit      = 1'b0;
        completes = 1'b0;
        if (has && !malformed)
        begin
            if (payload_left == '0)
            begin
                if (hdr_count != lpfs_pkg::HDR_LAST)
                begin
                    len_shift = {len_shift[lpfs_pkg::ACC_W-1:0], b};
                    hdr_count = hdr_count + 2'd1;
                end
                else
                begin
                    len       = {len_shift[lpfs_pkg::ACC_W-1:0], b};
                    hdr_count = '0;
                    len_shift = '0;
                    if (len == '0)
                        completes = 1'b1;
                    else
                        payload_left = len;
                end
            end
            else
            begin
                payload_left  = payload_left - 32'd1;
                r.out_byte    = b;
                r.byte_valid  = 1'b1;
                r.field_index = fields_done;
                if (payload_left == '0)
                    completes = 1'b1;
                else
                    emit = 1'b1;
            end
            if (completes)
            begin
                // A field beyond the limit spoils the message and its last word is dropped.
                if (fields_done >= 7'(MAX_FIELDS))
                begin
                    malformed     = 1'b1;
                    r.out_byte    = '0;
                    r.byte_valid  = 1'b0;
                    r.field_index = '0;
                end
                else
                begin
                    r.field_index = fields_done;
                    r.field_end   = 1'b1;
                    emit          = 1'b1;
                    fields_done   = fields_done + 7'd1;
                end
            end
        end
        if (eom)
        begin
            if (hdr_count != '0 || payload_left != '0)
                malformed = 1'b1;
            if (!emit)
            begin
                r.out_byte    = '0;
                r.byte_valid  = 1'b0;
                r.field_end   = 1'b0;
                r.field_index = fields_done;
            end
            r.message_done = 1'b1;
            r.well_formed  = !malformed;
            emit           = 1'b1;
            clear_parse();
        end
        if (emit)
            split_due.insert(split_due.size(), r);
    endtask

    task automatic check_result();
        lpfs_pkg::result_t seen;
        lpfs_pkg::result_t due;
        seen = {out_byte, byte_valid, field_index, field_end, message_done, well_formed};
        if (split_due.size() == 0)
        begin
            note_failure({"unexpected result word: ", show_result(seen)});
        end
        else
        begin
            due = split_due.pop_front();
            if (seen !== due)
            begin
                note_failure({"mismatch: expected ", show_result(due),
                              " got ", show_result(seen)});
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_due.delete();
            clear_parse();
            fail_total = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                predict_split(data_byte, has_byte, end_of_message);
            pending    <= split_due.size();
            mismatches <= fail_total;
        end
    end

endmodule

>>> tb/length_prefixed_field_splitter_test.sv
`timescale 1ns / 1ps
// Testbench top for the length-prefixed field splitter: clock, reset, message
// stimulus with random idling on both channels, and the final verdict.
// Depends on lpfs_pkg, the splitter RTL and lpfs_split_checker.
module length_prefixed_field_splitter_test;

    typedef enum int {MSG_CLEAN, MSG_TRUNCATED, MSG_NOISE, MSG_CROWDED} msg_kind_t;

    localparam int RANDOM_WORDS = 2000;
    localparam int CALM_WORDS   = 300;
    localparam int DRAIN_EVERY  = 25;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [lpfs_pkg::BYTE_W-1:0]  data_byte;
    logic                         has_byte;
    logic                         end_of_message;
    logic                         out_valid;
    logic                         out_ready;
    logic [lpfs_pkg::BYTE_W-1:0]  out_byte;
    logic                         byte_valid;
    logic [lpfs_pkg::INDEX_W-1:0] field_index;
    logic                         field_end;
    logic                         message_done;
    logic                         well_formed;
    int                           mismatches;
    int                           pending;

    int                           words_sent;
    int                           tx_gap_pct;
    int                           rx_stall_pct;
    bit                           calm;
    logic [lpfs_pkg::BYTE_W-1:0]  msg_bytes[$];

    length_prefixed_field_splitter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_index    (field_index),
        .field_end      (field_end),
        .message_done   (message_done),
        .well_formed    (well_formed)
    );

    lpfs_split_checker stream_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_index    (field_index),
        .field_end      (field_end),
        .message_done   (message_done),
        .well_formed    (well_formed),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    function automatic logic [lpfs_pkg::BYTE_W-1:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[lpfs_pkg::BYTE_W-1:0];
    endfunction

    function automatic void add_byte(input logic [lpfs_pkg::BYTE_W-1:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    task automatic send_word(input logic [lpfs_pkg::BYTE_W-1:0] b, input logic has,
                             input logic eom);
        if (!calm && $urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= b;
        has_byte       <= has;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (has || eom)
            words_sent++;
    endtask

    task automatic send_byte(input logic [lpfs_pkg::BYTE_W-1:0] b, input logic eom);
        if ($urandom_range(0, 99) < 4)
            send_word(rand_byte(), 1'b0, 1'b0);
        send_word(b, 1'b1, eom);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic int pick_len(input int max_len);
        if (max_len <= 6 || $urandom_range(0, 99) < 80)
            return $urandom_range(0, (max_len < 6) ? max_len : 6);
        return $urandom_range(7, max_len);
    endfunction

    function automatic void add_header(input logic [lpfs_pkg::LEN_W-1:0] len);
        for (int i = 3; i >= 0; i--)
            add_byte(len[8*i +: 8]);
    endfunction

    function automatic void add_fields(input int count, input int max_len);
        int len;
        for (int f = 0; f < count; f++)
        begin
            len = pick_len(max_len);
            add_header(len);
            for (int j = 0; j < len; j++)
                add_byte(rand_byte());
        end
    endfunction

    task automatic send_message(input bit end_with_byte);
        int n;
        n = msg_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(msg_bytes[i], end_with_byte && (i == n - 1));
        if (!end_with_byte || n == 0)
            send_word(rand_byte(), 1'b0, 1'b1);
        msg_bytes.delete();
    endtask

    task automatic build_random_message(input int msg_number);
        msg_kind_t                  kind;
        int                         pick;
        logic [lpfs_pkg::LEN_W-1:0] len;
        int                         cut;
        pick = $urandom_range(0, 99);
        if (msg_number < 2)
            kind = MSG_CROWDED;
        else if (pick < 72)
            kind = MSG_CLEAN;
        else if (pick < 86)
            kind = MSG_TRUNCATED;
        else if (pick < 97)
            kind = MSG_NOISE;
        else
            kind = MSG_CROWDED;
        case (kind)
            MSG_CLEAN:
                add_fields($urandom_range(0, 6), 40);
            MSG_TRUNCATED:
            begin
                add_fields($urandom_range(0, 2), 12);
                if ($urandom_range(0, 1) == 0)
                begin
                    repeat ($urandom_range(1, 3)) add_byte(rand_byte());
                end
                else
                begin
                    len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 30) : $urandom;
                    if (len == 0)
                        len = 1;
                    add_header(len);
                    cut = (len > 13) ? 12 : len - 1;
                    repeat ($urandom_range(0, cut)) add_byte(rand_byte());
                end
            end
            MSG_NOISE:
                repeat ($urandom_range(1, 30)) add_byte(rand_byte());
            MSG_CROWDED:
            begin
                add_fields((msg_number == 0) ? 64 : (msg_number == 1) ? 65 :
                           $urandom_range(63, 66), 2);
                repeat ($urandom_range(0, 5)) add_byte(rand_byte());
            end
            default: ;
        endcase
    endtask

    initial
    begin
        int target;
        int msg_number;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_byte      <= '0;
        has_byte       <= 1'b0;
        end_of_message <= 1'b0;
        calm           = 1'b0;
        tx_gap_pct     = 0;
        rx_stall_pct   = 0;
        words_sent     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, then a word with neither byte nor end.
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hA5, 1'b0, 1'b0);
        // Empty field, a two-byte field whose last byte closes the message.
        add_header(0);
        add_header(2);
        add_byte(8'hFF);
        add_byte(8'h00);
        send_message(1'b1);
        // End inside a header.
        add_byte(8'hFF);
        add_byte(8'hFF);
        add_byte(8'hFF);
        send_message(1'b1);
        // End inside a payload.
        add_header(5);
        add_byte(8'h55);
        add_byte(8'hAA);
        send_message(1'b0);

        target     = words_sent + RANDOM_WORDS;
        msg_number = 0;
        while (words_sent < target)
        begin
            calm         = (words_sent > target - CALM_WORDS);
            tx_gap_pct   = calm ? 0 : ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            rx_stall_pct = calm ? 0 : ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            build_random_message(msg_number);
            send_message($urandom_range(0, 1) == 1);
            if (msg_number % DRAIN_EVERY == 3)
                wait_drained();
            msg_number++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/lpfs_pkg.sv
hw/rtl/lpfs_parser.sv
hw/rtl/length_prefixed_field_splitter.sv
tb/lpfs_split_checker.sv
tb/length_prefixed_field_splitter_test.sv
